/* design/krt_pkg.sv */
// Shared constants, codes and the search word type for the keyed record table.
`default_nettype none
package krt_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_NEGATIVE  = 3'd5;

  typedef struct packed {
    logic              vld;
    logic [1:0]        cmd;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] qty;
    logic [DATA_W-1:0] price;
    logic [CNT_W-1:0]  rem;
    logic              hit;
    logic              placed;
    logic [DATA_W-1:0] hit_qty;
    logic [DATA_W-1:0] hit_price;
  } tok_t;

endpackage
`default_nettype wire

/* design/krt_cell.sv */
// One table cell: holds one record and passes the search word to its neighbor.
`default_nettype none
module krt_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire krt_pkg::tok_t tok_i,
  output krt_pkg::tok_t      tok_o
);
  import krt_pkg::*;

  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] qty_r, qty_nxt;
  logic [DATA_W-1:0] price_r, price_nxt;
  tok_t              tok_r, tok_nxt;
  logic              live;
  logic              match;
  logic              place;

  always_comb begin
    live      = (tok_i.rem != '0);
    match     = tok_i.vld && live && !tok_i.hit && (key_r == tok_i.key);
    place     = tok_i.vld && !live && !tok_i.placed && !tok_i.hit &&
                (tok_i.cmd == CMD_INSERT);
    tok_nxt   = tok_i;
    key_nxt   = key_r;
    qty_nxt   = qty_r;
    price_nxt = price_r;
    if (live) begin
      tok_nxt.rem = tok_i.rem - CNT_W'(1);
    end
    if (match) begin
      tok_nxt.hit       = 1'b1;
      tok_nxt.hit_qty   = qty_r;
      tok_nxt.hit_price = price_r;
      if ((tok_i.cmd == CMD_UPDATE) && !tok_i.qty[DATA_W-1]) begin
        qty_nxt = tok_i.qty;
      end
    end
    if (place) begin
      tok_nxt.placed = 1'b1;
      key_nxt        = tok_i.key;
      qty_nxt        = tok_i.qty;
      price_nxt      = tok_i.price;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      key_r   <= key_nxt;
      qty_r   <= qty_nxt;
      price_r <= price_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

/* design/keyed_record_table.sv */
// Top level: record count, search word launch, chain of cells and result register.
// An accepted word is registered at launch, walks the cell chain one cell a cycle
// and lands in the result register; in_ready stays low until its result is posted,
// so one word is in flight at a time. A held result stalls the whole chain.
// Reset clears the record count and all control; stored records need no reset.
`default_nettype none
module keyed_record_table (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_cmd,
  input  wire logic signed [31:0]   in_record_key,
  input  wire logic signed [31:0]   in_quantity_in,
  input  wire logic signed [31:0]   in_price_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                out_status,
  output logic signed [31:0]        out_quantity_out,
  output logic signed [31:0]        out_price_out
);
  import krt_pkg::*;

  tok_t              chain [TABLE_DEPTH+1];
  tok_t              tok_in_r, tok_in_nxt;
  tok_t              tok_end;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [DATA_W-1:0] qty_out_r, qty_out_nxt;
  logic [DATA_W-1:0] price_out_r, price_out_nxt;
  logic              en;
  logic              accept;
  logic              finish;
  logic [2:0]        res_status;
  logic [DATA_W-1:0] res_qty;
  logic [DATA_W-1:0] res_price;
  logic              res_inc;

  assign chain[0] = tok_in_r;
  assign tok_end  = chain[TABLE_DEPTH];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    krt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (chain[i]),
      .tok_o (chain[i+1])
    );
  end

  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign en       = !tok_end.vld || !out_valid_r || out_ready;
  assign finish   = tok_end.vld && en;

  always_comb begin
    res_status = ST_OK;
    res_qty    = '0;
    res_price  = '0;
    res_inc    = 1'b0;
    case (tok_end.cmd)
      CMD_INSERT: begin
        if (count_r >= CNT_W'(TABLE_DEPTH)) begin
          res_status = ST_FULL;
        end else if (tok_end.hit) begin
          res_status = ST_DUPLICATE;
        end else begin
          res_inc = 1'b1;
        end
      end
      CMD_LOOKUP, CMD_UPDATE: begin
        if (count_r == '0) begin
          res_status = ST_EMPTY;
        end else if (!tok_end.hit) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_qty   = tok_end.hit_qty;
          res_price = tok_end.hit_price;
          if ((tok_end.cmd == CMD_UPDATE) && tok_end.qty[DATA_W-1]) begin
            res_status = ST_NEGATIVE;
          end
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    tok_in_nxt    = tok_in_r;
    count_nxt     = count_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    qty_out_nxt   = qty_out_r;
    price_out_nxt = price_out_r;
    if (en) begin
      tok_in_nxt.vld = 1'b0;
    end
    if (accept) begin
      tok_in_nxt.vld       = 1'b1;
      tok_in_nxt.cmd       = in_cmd;
      tok_in_nxt.key       = in_record_key;
      tok_in_nxt.qty       = in_quantity_in;
      tok_in_nxt.price     = in_price_in;
      tok_in_nxt.rem       = count_r;
      tok_in_nxt.hit       = 1'b0;
      tok_in_nxt.placed    = 1'b0;
      tok_in_nxt.hit_qty   = '0;
      tok_in_nxt.hit_price = '0;
      busy_nxt             = 1'b1;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
      status_nxt    = res_status;
      qty_out_nxt   = res_qty;
      price_out_nxt = res_price;
      busy_nxt      = 1'b0;
      if (res_inc) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_in_r    <= '0;
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tok_in_r    <= tok_in_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    qty_out_r   <= qty_out_nxt;
    price_out_r <= price_out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_quantity_out = qty_out_r;
  assign out_price_out    = price_out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("record count above table depth");

  a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !tok_end.vld && !tok_in_r.vld)
    else $error("search word in flight while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && out_valid == $past(out_valid && !out_ready) || busy_r)
    else $error("accepted word did not start a search");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    finish && res_inc |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("successful insert did not advance the count");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r && !busy_r)
    else $error("finished search did not post a result");

endmodule
`default_nettype wire

/* sim/keyed_record_table_tb.sv */
// Self-checking testbench for keyed_record_table: directed and random commands with a ledger.
`timescale 1ns / 1ps
module keyed_record_table_tb;
  import krt_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_WORDS_PER_PHASE = 350;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
  localparam realtime RUN_LIMIT = 40ms;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] qty;
    logic [31:0] price;
  } reply_t;

  class record_ledger;
    logic [31:0] keys [TABLE_DEPTH];
    logic [31:0] qtys [TABLE_DEPTH];
    logic [31:0] prices [TABLE_DEPTH];
    int unsigned count;
    reply_t pending_replies[$];
    int unsigned mismatches;

    function new();
      count = 0;
      mismatches = 0;
    endfunction

    function int find_key(logic [31:0] key);
      for (int i = 0; i < count; i++) begin
        if (keys[i] == key) return i;
      end
      return -1;
    endfunction

    function void note_command(logic [1:0] cmd, logic [31:0] key, logic [31:0] qty,
                               logic [31:0] price);
      reply_t r;
      int idx;
      r.status = ST_OK;
      r.qty = '0;
      r.price = '0;
      idx = find_key(key);
      case (cmd)
        CMD_INSERT: begin
          if (count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else if (idx >= 0) begin
            r.status = ST_DUPLICATE;
          end else begin
            keys[count] = key;
            qtys[count] = qty;
            prices[count] = price;
            count++;
          end
        end
        CMD_LOOKUP, CMD_UPDATE: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else if (idx < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.qty = qtys[idx];
            r.price = prices[idx];
            if (cmd == CMD_UPDATE) begin
              if (qty[31]) r.status = ST_NEGATIVE;
              else qtys[idx] = qty;
            end
          end
        end
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [2:0] status, logic [31:0] qty, logic [31:0] price);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word: status %0d qty %0d price %0d",
                   $realtime, status, $signed(qty), $signed(price));
        return;
      end
      want = pending_replies.pop_front();
      if (want.status !== status || want.qty !== qty || want.price !== price) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected status %0d qty %0d price %0d, got status %0d qty %0d price %0d",
                   $realtime, want.status, $signed(want.qty), $signed(want.price),
                   status, $signed(qty), $signed(price));
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_cmd;
  logic signed [31:0] in_record_key;
  logic signed [31:0] in_quantity_in;
  logic signed [31:0] in_price_in;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_status;
  logic signed [31:0] out_quantity_out;
  logic signed [31:0] out_price_out;

  int idle_pct;
  int stall_pct;
  record_ledger ledger;

  keyed_record_table DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_record_key(in_record_key),
    .in_quantity_in(in_quantity_in),
    .in_price_in(in_price_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_quantity_out(out_quantity_out),
    .out_price_out(out_price_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        ledger.note_command(in_cmd, in_record_key, in_quantity_in, in_price_in);
      if (out_valid && out_ready)
        ledger.check_reply(out_status, out_quantity_out, out_price_out);
    end
  end

  function automatic logic [31:0] field_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [31:0] key,
                           input logic [31:0] qty, input logic [31:0] price);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct)
      gap = $urandom_range(1) ? $urandom_range(1, 6) : $urandom_range(1, 2 * TABLE_DEPTH + 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_record_key <= key;
    in_quantity_in <= qty;
    in_price_in <= price;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_word();
    int pick;
    int insert_share;
    logic [1:0] cmd;
    logic [31:0] key;
    pick = $urandom_range(99);
    insert_share = (ledger.count < TABLE_DEPTH) ? 45 : 12;
    if (pick < 3) cmd = CMD_UNUSED;
    else if (pick < 3 + insert_share) cmd = CMD_INSERT;
    else if ($urandom_range(1)) cmd = CMD_LOOKUP;
    else cmd = CMD_UPDATE;
    if (ledger.count > 0 && $urandom_range(99) < ((cmd == CMD_INSERT) ? 25 : 75))
      key = ledger.keys[$urandom_range(ledger.count - 1)];
    else
      key = field_value();
    send_word(cmd, key, field_value(), field_value());
  endtask

  initial begin
    ledger = new();
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_INSERT;
    in_record_key = '0;
    in_quantity_in = '0;
    in_price_in = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_UPDATE, 32'hffff_ffff, 32'h0000_0005, 32'h0000_0000);
    send_word(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(CMD_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_word(CMD_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_word(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(CMD_INSERT, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
    send_word(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_LOOKUP, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_word(CMD_LOOKUP, 32'h0000_3039, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_UPDATE, 32'h0000_3039, 32'h0000_0007, 32'h0000_0000);
    send_word(CMD_UPDATE, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
    send_word(CMD_UPDATE, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_UPDATE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000);
    send_word(CMD_UPDATE, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0000);
    send_word(CMD_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_UNUSED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(CMD_INSERT, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_word(CMD_LOOKUP, 32'h5555_5555, 32'h0000_0000, 32'h0000_0000);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      repeat (RANDOM_WORDS_PER_PHASE) send_random_word();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ledger.mismatches == 0 && ledger.pending_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
